@@ sv/c2dwp_pkg.sv @@
// Package for the 2D window convolution block.
// Holds the action codes, register indexes and the fixed field widths.
// No dependencies.
`default_nettype none

package c2dwp_pkg;

    localparam int ACTION_W     = 2;
    localparam int COEF_INDEX_W = 6;
    localparam int COEF_W       = 18;
    localparam int PIX_W        = 16;

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 13;
    localparam int FW_REG_W     = 9;
    localparam int FH_REG_W     = 13;
    localparam int NC_REG_W     = 3;
    localparam int K_REG_W      = 3;

    localparam logic [ACTION_W-1:0] ACT_COEF  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_HEIGHT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PADDING_MODE  = 3'd5;

    localparam logic PAD_ZERO   = 1'b0;
    localparam logic PAD_MIRROR = 1'b1;

    localparam int ROUND_SHIFT = 16;
    localparam int RESULT_MAX  = 32767;
    localparam int RESULT_MIN  = -32768;

endpackage

`default_nettype wire

@@ sv/c2dwp_front.sv @@
// Front end: configuration registers, input transaction decode, input and
// output position counters and the readiness check. Depends on c2dwp_pkg.
`default_nettype none

module c2dwp_front #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 4096,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_KERNEL   = 7,
    localparam int XW        = $clog2(MAX_WIDTH),
    localparam int YW        = $clog2(MAX_HEIGHT),
    localparam int CW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int WB        = $clog2(MAX_WIDTH + 1),
    localparam int HB        = $clog2(MAX_HEIGHT + 1),
    localparam int KB        = $clog2(MAX_KERNEL + 1),
    localparam int LINE_ROWS = MAX_KERNEL + 1,
    localparam int SW        = $clog2(LINE_ROWS),
    localparam int JOB_BITS  = XW + YW + CW + SW + 1,
    localparam int CFG_BITS  = WB + HB + 2 * KB + 1,
    localparam int AW        = SW + XW + CW
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire [c2dwp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [c2dwp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                  item_valid,
    output logic                                 item_stall,
    input  wire [c2dwp_pkg::ACTION_W-1:0]        action,
    input  wire [c2dwp_pkg::COEF_INDEX_W-1:0]    coef_index,
    input  wire signed [c2dwp_pkg::COEF_W-1:0]   coef_value,
    input  wire signed [c2dwp_pkg::PIX_W-1:0]    pixel_value,
    input  wire                                  back_idle,
    output logic                                 job_push,
    output logic [JOB_BITS-1:0]                  job_data,
    output logic [CFG_BITS-1:0]                  cfg_bus,
    output logic                                 st_we,
    output logic [AW-1:0]                        st_addr,
    output logic signed [c2dwp_pkg::PIX_W-1:0]   st_data,
    output logic                                 cf_we,
    output logic [c2dwp_pkg::COEF_INDEX_W-1:0]   cf_addr,
    output logic signed [c2dwp_pkg::COEF_W-1:0]  cf_data
);
    import c2dwp_pkg::*;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [CW-1:0] c;
        logic [SW-1:0] slot;
        logic          last;
    } job_t;

    typedef struct packed {
        logic [WB-1:0] w;
        logic [HB-1:0] h;
        logic [KB-1:0] kw;
        logic [KB-1:0] kh;
        logic          pad;
    } cfg_t;

    logic [FW_REG_W-1:0] frame_width_reg;
    logic [FH_REG_W-1:0] frame_height_reg;
    logic [NC_REG_W-1:0] channel_count_reg;
    logic [K_REG_W-1:0]  kernel_width_reg;
    logic [K_REG_W-1:0]  kernel_height_reg;
    logic                padding_mode_reg;

    logic [XW-1:0] in_column_reg, in_column_next;
    logic [YW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] in_chan_reg, in_chan_next;
    logic [SW-1:0] in_slot_reg, in_slot_next;
    logic [XW-1:0] emit_column_reg, emit_column_next;
    logic [YW-1:0] emit_row_reg, emit_row_next;
    logic [CW-1:0] emit_chan_reg, emit_chan_next;
    logic [SW-1:0] emit_slot_reg, emit_slot_next;
    logic          done_reg, done_next;

    logic [WB-1:0] w_lim;
    logic [HB-1:0] h_lim;
    logic [NC_REG_W:0] nc_lim;
    logic [KB-1:0] kw_lim, kh_lim;
    logic [XW-1:0] w_m1;
    logic [YW-1:0] h_m1;
    logic [CW-1:0] nc_m1;
    logic [KB-1:0] rx, ry;

    logic          accept, take_pix, emit_item, in_last, ready, behind;
    logic [XW-1:0] col_c, ncol;
    logic [CW-1:0] ch_c, ec;
    logic [YW-1:0] nr;
    logic [YW:0]   nr_sum;
    logic [XW:0]   ncol_sum;
    job_t          job;
    cfg_t          cfg;

    // Register values outside the legal range act as the nearest legal value.
    always_comb
    begin
        if (frame_width_reg == '0)
            w_lim = WB'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_lim = WB'(MAX_WIDTH);
        else
            w_lim = WB'(frame_width_reg);
        if (frame_height_reg == '0)
            h_lim = HB'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_lim = HB'(MAX_HEIGHT);
        else
            h_lim = HB'(frame_height_reg);
        if (channel_count_reg == '0)
            nc_lim = (NC_REG_W + 1)'(1);
        else if (32'(channel_count_reg) > MAX_CHANNELS)
            nc_lim = (NC_REG_W + 1)'(MAX_CHANNELS);
        else
            nc_lim = (NC_REG_W + 1)'(channel_count_reg);
        kw_lim = (32'(kernel_width_reg) > MAX_KERNEL) ? KB'(MAX_KERNEL)
                                                       : KB'(kernel_width_reg);
        kh_lim = (32'(kernel_height_reg) > MAX_KERNEL) ? KB'(MAX_KERNEL)
                                                        : KB'(kernel_height_reg);
    end

    assign w_m1  = XW'(w_lim - WB'(1));
    assign h_m1  = YW'(h_lim - HB'(1));
    assign nc_m1 = CW'(nc_lim - (NC_REG_W + 1)'(1));
    assign rx    = kw_lim >> 1;
    assign ry    = kh_lim >> 1;

    always_comb
    begin
        cfg.w   = w_lim;
        cfg.h   = h_lim;
        cfg.kw  = kw_lim;
        cfg.kh  = kh_lim;
        cfg.pad = padding_mode_reg;
    end
    assign cfg_bus = cfg;

    // Only one transaction is in flight past the front at a time, so the
    // line store and coefficients never change under a running window.
    assign item_stall = !back_idle;
    assign accept     = item_valid && !item_stall;
    assign take_pix   = accept && (action == ACT_PIXEL) && !done_reg;
    assign emit_item  = accept && ((action == ACT_PIXEL) || (action == ACT_FLUSH));

    assign col_c   = (in_column_reg > w_m1) ? w_m1 : in_column_reg;
    assign ch_c    = (in_chan_reg > nc_m1) ? nc_m1 : in_chan_reg;
    assign in_last = (col_c == w_m1) && (in_row_reg >= h_m1) && (ch_c == nc_m1);

    assign st_we   = take_pix;
    assign st_addr = {in_slot_reg, col_c, ch_c};
    assign st_data = pixel_value;

    assign cf_we   = accept && (action == ACT_COEF);
    assign cf_addr = coef_index;
    assign cf_data = coef_value;

    assign nr_sum   = {1'b0, emit_row_reg} + (YW + 1)'(ry);
    assign nr       = (nr_sum > {1'b0, h_m1}) ? h_m1 : YW'(nr_sum);
    assign ncol_sum = {1'b0, emit_column_reg} + (XW + 1)'(rx);
    assign ncol     = (ncol_sum > {1'b0, w_m1}) ? w_m1 : XW'(ncol_sum);
    assign ec       = (emit_chan_reg > nc_m1) ? nc_m1 : emit_chan_reg;

    always_comb
    begin
        in_column_next   = in_column_reg;
        in_row_next      = in_row_reg;
        in_chan_next     = in_chan_reg;
        in_slot_next     = in_slot_reg;
        done_next        = done_reg;
        emit_column_next = emit_column_reg;
        emit_row_next    = emit_row_reg;
        emit_chan_next   = emit_chan_reg;
        emit_slot_next   = emit_slot_reg;

        if (take_pix)
        begin
            if (in_last)
                done_next = 1'b1;
            else if ((NC_REG_W + 1)'(in_chan_reg) + (NC_REG_W + 1)'(1) >= nc_lim)
            begin
                in_chan_next = '0;
                if (WB'(in_column_reg) + WB'(1) >= w_lim)
                begin
                    in_column_next = '0;
                    in_row_next    = in_row_reg + YW'(1);
                    in_slot_next   = (in_slot_reg == SW'(LINE_ROWS - 1)) ? '0
                                   : in_slot_reg + SW'(1);
                end
                else
                    in_column_next = in_column_reg + XW'(1);
            end
            else
                in_chan_next = in_chan_reg + CW'(1);
        end

        // The output position is ready once the bottom-right sample of its
        // window (clipped to the frame) has arrived, or the frame is all in.
        behind = (nr < in_row_next)
              || ((nr == in_row_next) && ((ncol < in_column_next)
              || ((ncol == in_column_next) && (ec < in_chan_next))));
        ready  = done_next || behind;

        job.x    = emit_column_reg;
        job.y    = emit_row_reg;
        job.c    = ec;
        job.slot = emit_slot_reg;
        job.last = (emit_column_reg >= w_m1) && (emit_row_reg >= h_m1) && (ec == nc_m1);

        job_push = emit_item && ready;

        if (job_push)
        begin
            if (job.last)
            begin
                in_column_next   = '0;
                in_row_next      = '0;
                in_chan_next     = '0;
                in_slot_next     = '0;
                done_next        = 1'b0;
                emit_column_next = '0;
                emit_row_next    = '0;
                emit_chan_next   = '0;
                emit_slot_next   = '0;
            end
            else if ((NC_REG_W + 1)'(emit_chan_reg) + (NC_REG_W + 1)'(1) >= nc_lim)
            begin
                emit_chan_next = '0;
                if (WB'(emit_column_reg) + WB'(1) >= w_lim)
                begin
                    emit_column_next = '0;
                    emit_row_next    = emit_row_reg + YW'(1);
                    emit_slot_next   = (emit_slot_reg == SW'(LINE_ROWS - 1)) ? '0
                                     : emit_slot_reg + SW'(1);
                end
                else
                    emit_column_next = emit_column_reg + XW'(1);
            end
            else
                emit_chan_next = emit_chan_reg + CW'(1);
        end
    end

    assign job_data = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FW_REG_W'(256);
            frame_height_reg  <= FH_REG_W'(256);
            channel_count_reg <= NC_REG_W'(1);
            kernel_width_reg  <= K_REG_W'(3);
            kernel_height_reg <= K_REG_W'(3);
            padding_mode_reg  <= PAD_ZERO;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[FW_REG_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[FH_REG_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[NC_REG_W-1:0];
                REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[K_REG_W-1:0];
                REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[K_REG_W-1:0];
                REG_PADDING_MODE:  padding_mode_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg   <= '0;
            in_row_reg      <= '0;
            in_chan_reg     <= '0;
            in_slot_reg     <= '0;
            done_reg        <= 1'b0;
            emit_column_reg <= '0;
            emit_row_reg    <= '0;
            emit_chan_reg   <= '0;
            emit_slot_reg   <= '0;
        end
        else
        begin
            in_column_reg   <= in_column_next;
            in_row_reg      <= in_row_next;
            in_chan_reg     <= in_chan_next;
            in_slot_reg     <= in_slot_next;
            done_reg        <= done_next;
            emit_column_reg <= emit_column_next;
            emit_row_reg    <= emit_row_next;
            emit_chan_reg   <= emit_chan_next;
            emit_slot_reg   <= emit_slot_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/c2dwp_queue.sv @@
// Two-entry job queue between the front end and the window engine.
// Generic payload width; no package dependencies.
`default_nettype none

module c2dwp_queue #(
    parameter int WIDTH = 8
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  push_data,
    input  wire              pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             valid
);
    logic [WIDTH-1:0] entry_reg [2];
    logic [1:0]       count_reg;
    logic             rd_ptr_reg;
    logic             wr_ptr_reg;
    logic             do_pop;

    assign valid    = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_pop   = pop && valid;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

@@ sv/c2dwp_back.sv @@
// Window engine: line store, coefficient store and one multiply-accumulate
// unit stepped over the kernel taps, then rounding and the output register.
// Depends on c2dwp_pkg.
`default_nettype none

module c2dwp_back #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 4096,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_KERNEL   = 7,
    localparam int XW        = $clog2(MAX_WIDTH),
    localparam int YW        = $clog2(MAX_HEIGHT),
    localparam int CW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int WB        = $clog2(MAX_WIDTH + 1),
    localparam int HB        = $clog2(MAX_HEIGHT + 1),
    localparam int KB        = $clog2(MAX_KERNEL + 1),
    localparam int LINE_ROWS = MAX_KERNEL + 1,
    localparam int SW        = $clog2(LINE_ROWS),
    localparam int JOB_BITS  = XW + YW + CW + SW + 1,
    localparam int CFG_BITS  = WB + HB + 2 * KB + 1,
    localparam int AW        = SW + XW + CW
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire [CFG_BITS-1:0]                   cfg_bus,
    input  wire                                  job_valid,
    input  wire [JOB_BITS-1:0]                   job_data,
    output logic                                 job_pop,
    output logic                                 busy,
    input  wire                                  st_we,
    input  wire [AW-1:0]                         st_addr,
    input  wire signed [c2dwp_pkg::PIX_W-1:0]    st_data,
    input  wire                                  cf_we,
    input  wire [c2dwp_pkg::COEF_INDEX_W-1:0]    cf_addr,
    input  wire signed [c2dwp_pkg::COEF_W-1:0]   cf_data,
    output logic                                 result_valid,
    input  wire                                  result_stall,
    output logic signed [c2dwp_pkg::PIX_W-1:0]   result_value,
    output logic [XW-1:0]                        out_x,
    output logic [YW-1:0]                        out_y,
    output logic [CW-1:0]                        out_channel,
    output logic                                 saturated,
    output logic                                 last
);
    import c2dwp_pkg::*;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [CW-1:0] c;
        logic [SW-1:0] slot;
        logic          last;
    } job_t;

    typedef struct packed {
        logic [WB-1:0] w;
        logic [HB-1:0] h;
        logic [KB-1:0] kw;
        logic [KB-1:0] kh;
        logic          pad;
    } cfg_t;

    localparam int DEPTH  = LINE_ROWS << (XW + CW);
    localparam int CDEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int CIW    = $clog2(CDEPTH);
    localparam int PROD_W = PIX_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(CDEPTH) + 1;
    localparam int Q_W    = ACC_W - ROUND_SHIFT;
    localparam int SXW    = XW + 2;
    localparam int SYW    = YW + 2;
    localparam int DW     = SW + 2;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    cfg_t cfg;
    job_t job_reg;

    logic [1:0]    state_reg;
    logic [KB-1:0] kx_reg, ky_reg;
    logic [KB-1:0] rx, ry;

    logic signed [PIX_W-1:0]  line_mem [DEPTH];
    logic signed [COEF_W-1:0] coef_mem [CDEPTH];
    logic [CDEPTH-1:0]        coef_valid_reg;

    logic                     s1_valid_reg, s1_zero_reg, coef_ok_reg;
    logic signed [PIX_W-1:0]  pix_rd_reg;
    logic signed [COEF_W-1:0] coef_rd_reg;
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                     issue, last_tap, cf_ok, out_free;
    logic [CIW-1:0]           cf_idx, coef_raddr;
    logic [AW-1:0]            rd_addr;
    logic signed [SXW-1:0]    sx, mx1, mx2, mx3, w_s;
    logic signed [SYW-1:0]    sy, my1, my2, my3, h_s, dy;
    logic signed [DW-1:0]     slot_sum, slot_fix;
    logic                     outside, tap_zero;
    logic signed [PIX_W-1:0]  pix_eff;
    logic signed [COEF_W-1:0] coef_eff;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [Q_W-1:0]    q;

    assign cfg = cfg_bus;
    assign rx  = cfg.kw >> 1;
    assign ry  = cfg.kh >> 1;

    assign busy     = (state_reg != ST_IDLE);
    assign job_pop  = (state_reg == ST_IDLE) && job_valid;
    assign issue    = (state_reg == ST_RUN);
    assign last_tap = (kx_reg == cfg.kw - KB'(1)) && (ky_reg == cfg.kh - KB'(1));
    assign out_free = !result_valid || !result_stall;

    // Tap position with mirror folding; samples outside the frame are
    // zeroed afterwards in zero padding mode.
    always_comb
    begin
        w_s = SXW'(cfg.w);
        h_s = SYW'(cfg.h);
        sx  = SXW'(job_reg.x) + SXW'(kx_reg) - SXW'(rx);
        sy  = SYW'(job_reg.y) + SYW'(ky_reg) - SYW'(ry);
        outside = (sx < 0) || (sx >= w_s) || (sy < 0) || (sy >= h_s);

        mx1 = (sx < 0) ? -sx : sx;
        mx2 = (mx1 >= w_s) ? SXW'(2 * (w_s - 1) - mx1) : mx1;
        mx3 = (mx2 < 0) ? '0 : ((mx2 > w_s - 1) ? SXW'(w_s - 1) : mx2);

        my1 = (sy < 0) ? -sy : sy;
        my2 = (my1 >= h_s) ? SYW'(2 * (h_s - 1) - my1) : my1;
        my3 = (my2 < 0) ? '0 : ((my2 > h_s - 1) ? SYW'(h_s - 1) : my2);

        // The folded row stays within the kernel radius of the output row,
        // so its line slot is one wrap away from the output row's slot.
        dy       = my3 - SYW'(job_reg.y);
        slot_sum = DW'(job_reg.slot) + DW'(dy);
        if (slot_sum < 0)
            slot_fix = slot_sum + DW'(LINE_ROWS);
        else if (slot_sum >= DW'(LINE_ROWS))
            slot_fix = slot_sum - DW'(LINE_ROWS);
        else
            slot_fix = slot_sum;

        tap_zero   = outside && (cfg.pad == PAD_ZERO);
        rd_addr    = {SW'(slot_fix), XW'(mx3), job_reg.c};
        coef_raddr = CIW'(32'(ky_reg) * MAX_KERNEL + 32'(kx_reg));
    end

    assign cf_ok  = cf_we && (32'(cf_addr) < CDEPTH);
    assign cf_idx = CIW'(cf_addr);

    always_ff @(posedge clk)
    begin
        if (st_we)
            line_mem[st_addr] <= st_data;
        pix_rd_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cf_ok)
            coef_mem[cf_idx] <= cf_data;
        coef_rd_reg <= coef_mem[coef_raddr];
    end

    assign pix_eff  = s1_zero_reg ? '0 : pix_rd_reg;
    assign coef_eff = coef_ok_reg ? coef_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        prod_reg <= pix_eff * coef_eff;
    end

    // Round to nearest with ties upward, then clip to the sample range.
    assign rounded = acc_reg + ACC_W'(1 << (ROUND_SHIFT - 1));
    assign q       = Q_W'(rounded >>> ROUND_SHIFT);

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            if (q > RESULT_MAX)
            begin
                result_value <= PIX_W'(RESULT_MAX);
                saturated    <= 1'b1;
            end
            else if (q < RESULT_MIN)
            begin
                result_value <= PIX_W'(RESULT_MIN);
                saturated    <= 1'b1;
            end
            else
            begin
                result_value <= PIX_W'(q);
                saturated    <= 1'b0;
            end
            out_x       <= job_reg.x;
            out_y       <= job_reg.y;
            out_channel <= job_reg.c;
            last        <= job_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kx_reg         <= '0;
            ky_reg         <= '0;
            coef_valid_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s1_zero_reg    <= 1'b0;
            coef_ok_reg    <= 1'b0;
            s2_valid_reg   <= 1'b0;
            acc_reg        <= '0;
            result_valid   <= 1'b0;
        end
        else
        begin
            if (cf_ok)
                coef_valid_reg[cf_idx] <= 1'b1;

            s1_valid_reg <= issue;
            s1_zero_reg  <= tap_zero;
            coef_ok_reg  <= coef_valid_reg[coef_raddr];
            s2_valid_reg <= s1_valid_reg;

            if (job_pop)
                acc_reg <= '0;
            else if (s2_valid_reg)
                acc_reg <= acc_reg + ACC_W'(prod_reg);

            if ((state_reg == ST_FINISH) && out_free)
                result_valid <= 1'b1;
            else if (!result_stall)
                result_valid <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        kx_reg    <= '0;
                        ky_reg    <= '0;
                        state_reg <= ((cfg.kw == '0) || (cfg.kh == '0)) ? ST_DRAIN
                                                                       : ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (last_tap)
                        state_reg <= ST_DRAIN;
                    if (kx_reg == cfg.kw - KB'(1))
                    begin
                        kx_reg <= '0;
                        ky_reg <= ky_reg + KB'(1);
                    end
                    else
                        kx_reg <= kx_reg + KB'(1);
                end
                ST_DRAIN:
                begin
                    if (!s1_valid_reg && !s2_valid_reg)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("rounding started with products still in the pipeline");

    a_s2_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("product stage valid without a preceding read");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("tap read outstanding outside of a window pass");
`endif

endmodule

`default_nettype wire

@@ sv/conv2d_window_padding.sv @@
// Top level of the streaming 2D window convolution block.
// Instantiates c2dwp_front, c2dwp_queue and c2dwp_back; uses c2dwp_pkg.
`default_nettype none

// Pixels stream in raster order, channels interleaved, one sample per
// transaction; coefficients are loaded by transactions with action zero, and
// flush transactions drain the outputs that remain after the last pixel.
// Transactions that produce no output (coefficient loads, pixels whose
// output is not yet ready) do not start the window engine. A transaction
// that produces an output starts it: the window engine reads the line store
// and coefficient store once per kernel tap and feeds a single
// multiply-accumulate unit, then rounds and saturates. The result waits in
// an output register so the next transaction can enter while it is still
// stalled. The line store needs no clearing after reset.

module conv2d_window_padding #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 4096,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_KERNEL   = 7
) (
    input  wire                                                 clk,
    input  wire                                                 rst_n,
    input  wire                                                 cfg_write,
    input  wire [c2dwp_pkg::CFG_INDEX_W-1:0]                    cfg_index,
    input  wire [c2dwp_pkg::CFG_DATA_W-1:0]                     cfg_data,
    input  wire                                                 item_valid,
    output logic                                                item_stall,
    input  wire [c2dwp_pkg::ACTION_W-1:0]                       action,
    input  wire [c2dwp_pkg::COEF_INDEX_W-1:0]                   coef_index,
    input  wire signed [c2dwp_pkg::COEF_W-1:0]                  coef_value,
    input  wire signed [c2dwp_pkg::PIX_W-1:0]                   pixel_value,
    output logic                                                result_valid,
    input  wire                                                 result_stall,
    output logic signed [c2dwp_pkg::PIX_W-1:0]                  result_value,
    output logic [$clog2(MAX_WIDTH)-1:0]                        out_x,
    output logic [$clog2(MAX_HEIGHT)-1:0]                       out_y,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] out_channel,
    output logic                                                saturated,
    output logic                                                last
);
    import c2dwp_pkg::*;

    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int CW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WB        = $clog2(MAX_WIDTH + 1);
    localparam int HB        = $clog2(MAX_HEIGHT + 1);
    localparam int KB        = $clog2(MAX_KERNEL + 1);
    localparam int LINE_ROWS = MAX_KERNEL + 1;
    localparam int SW        = $clog2(LINE_ROWS);
    localparam int JOB_BITS  = XW + YW + CW + SW + 1;
    localparam int CFG_BITS  = WB + HB + 2 * KB + 1;
    localparam int AW        = SW + XW + CW;

    logic                      back_busy, back_idle;
    logic                      job_push, job_pop, job_valid;
    logic [JOB_BITS-1:0]       job_in, job_out;
    logic [CFG_BITS-1:0]       cfg_bus;
    logic                      st_we;
    logic [AW-1:0]             st_addr;
    logic signed [PIX_W-1:0]   st_data;
    logic                      cf_we;
    logic [COEF_INDEX_W-1:0]   cf_addr;
    logic signed [COEF_W-1:0]  cf_data;

    assign back_idle = !back_busy && !job_valid;

    c2dwp_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_KERNEL   (MAX_KERNEL)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .action      (action),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .pixel_value (pixel_value),
        .back_idle   (back_idle),
        .job_push    (job_push),
        .job_data    (job_in),
        .cfg_bus     (cfg_bus),
        .st_we       (st_we),
        .st_addr     (st_addr),
        .st_data     (st_data),
        .cf_we       (cf_we),
        .cf_addr     (cf_addr),
        .cf_data     (cf_data)
    );

    c2dwp_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .pop_data  (job_out),
        .valid     (job_valid)
    );

    c2dwp_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_KERNEL   (MAX_KERNEL)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_bus      (cfg_bus),
        .job_valid    (job_valid),
        .job_data     (job_out),
        .job_pop      (job_pop),
        .busy         (back_busy),
        .st_we        (st_we),
        .st_addr      (st_addr),
        .st_data      (st_data),
        .cf_we        (cf_we),
        .cf_addr      (cf_addr),
        .cf_data      (cf_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_value (result_value),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_channel  (out_channel),
        .saturated    (saturated),
        .last         (last)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for conv2d_window_padding.
// Streams frames of pixels, coefficient loads and flushes, predicts each output
// sample in a scoreboard class and compares it; uses c2dwp_pkg.
`timescale 1ns / 1ps

module tb;
    import c2dwp_pkg::*;

    localparam int STORE_ROWS   = 8;
    localparam int STORE_WIDTH  = 256;
    localparam int STORE_CHANS  = 4;
    localparam int KMAX         = 7;
    localparam int COEFS        = KMAX * KMAX;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_AT      = 30;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 200;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [15:0] value;
        logic [7:0]         x;
        logic [11:0]        y;
        logic [1:0]         chan;
        logic               sat;
        logic               last;
    } out_sample_t;

    class conv_scoreboard;
        logic [8:0]  fw;
        logic [12:0] fh;
        logic [2:0]  nch;
        logic [2:0]  kw;
        logic [2:0]  kh;
        logic        pad;
        int          coef[COEFS];
        int          line_mem[STORE_ROWS*STORE_WIDTH*STORE_CHANS];
        int unsigned in_x, in_y, in_c, em_x, em_y, em_c;
        bit          in_done;
        out_sample_t expected_outputs[$];
        int unsigned mismatches;

        function new();
            fw = 256; fh = 256; nch = 1; kw = 3; kh = 3; pad = PAD_ZERO;
            foreach (coef[i]) coef[i] = 0;
            foreach (line_mem[i]) line_mem[i] = 0;
            in_x = 0; in_y = 0; in_c = 0; em_x = 0; em_y = 0; em_c = 0;
            in_done = 0;
            mismatches = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [12:0] data);
            case (idx)
                REG_FRAME_WIDTH:   fw = data[8:0];
                REG_FRAME_HEIGHT:  fh = data;
                REG_CHANNEL_COUNT: nch = data[2:0];
                REG_KERNEL_WIDTH:  kw = data[2:0];
                REG_KERNEL_HEIGHT: kh = data[2:0];
                REG_PADDING_MODE:  pad = data[0];
                default: ;
            endcase
        endfunction

        function bit frame_idle();
            return in_x == 0 && in_y == 0 && in_c == 0 && em_x == 0 && em_y == 0
                && em_c == 0 && !in_done;
        endfunction

        function int reflect(int i, int n);
            if (i < 0) i = -i;
            if (i >= n) i = 2 * (n - 1) - i;
            if (i < 0) i = 0;
            if (i > n - 1) i = n - 1;
            return i;
        endfunction

        function void note_input(logic [1:0] act, logic [5:0] idx,
                                 logic signed [17:0] cval, logic signed [15:0] pix);
            int unsigned w, h, nc, rx, ry, ec, col, ch;
            longint need, have, nr, ncl, acc, t, q;
            int sx, sy, smp;
            out_sample_t o;
            if (act == ACT_COEF) begin
                if (idx < COEFS) coef[idx] = int'(cval);
                return;
            end
            if (act != ACT_PIXEL && act != ACT_FLUSH) return;
            w  = (fw == 0) ? 1 : (fw > 256 ? 256 : fw);
            h  = (fh == 0) ? 1 : (fh > 4096 ? 4096 : fh);
            nc = (nch == 0) ? 1 : (nch > 4 ? 4 : nch);
            if (act == ACT_PIXEL && !in_done) begin
                col = in_x < w ? in_x : w - 1;
                ch  = in_c < nc ? in_c : nc - 1;
                line_mem[((in_y % STORE_ROWS) * STORE_WIDTH + col) * STORE_CHANS + ch]
                    = int'(pix);
                if (col >= w - 1 && in_y >= h - 1 && ch >= nc - 1) in_done = 1;
                else if (++in_c >= nc) begin
                    in_c = 0;
                    if (++in_x >= w) begin
                        in_x = 0;
                        in_y++;
                    end
                end
            end
            rx = kw / 2;
            ry = kh / 2;
            ec = em_c < nc ? em_c : nc - 1;
            if (!in_done) begin
                nr  = em_y + ry;
                ncl = em_x + rx;
                if (nr > h - 1) nr = h - 1;
                if (ncl > w - 1) ncl = w - 1;
                need = (nr * w + ncl) * nc + ec;
                have = (longint'(in_y) * w + in_x) * nc + in_c;
                if (need >= have) return;
            end
            acc = 0;
            for (int ky = 0; ky < kh; ky++) begin
                for (int kx = 0; kx < kw; kx++) begin
                    sx = int'(em_x) + kx - int'(rx);
                    sy = int'(em_y) + ky - int'(ry);
                    if ((sx < 0 || sx >= int'(w) || sy < 0 || sy >= int'(h))
                        && pad == PAD_ZERO) begin
                        smp = 0;
                    end else begin
                        sx = reflect(sx, w);
                        sy = reflect(sy, h);
                        smp = line_mem[((sy % STORE_ROWS) * STORE_WIDTH + sx)
                                       * STORE_CHANS + ec];
                    end
                    acc += longint'(smp) * longint'(coef[ky * KMAX + kx]);
                end
            end
            // Round to nearest, then an arithmetic shift floors the quotient.
            t = acc + 32768;
            q = t >>> ROUND_SHIFT;
            o.sat = 0;
            if (q > RESULT_MAX) begin q = RESULT_MAX; o.sat = 1; end
            if (q < RESULT_MIN) begin q = RESULT_MIN; o.sat = 1; end
            o.value = q[15:0];
            o.x = em_x[7:0];
            o.y = em_y[11:0];
            o.chan = ec[1:0];
            o.last = em_x >= w - 1 && em_y >= h - 1 && ec >= nc - 1;
            expected_outputs.push_back(o);
            if (o.last) begin
                in_x = 0; in_y = 0; in_c = 0; em_x = 0; em_y = 0; em_c = 0;
                in_done = 0;
            end else if (++em_c >= nc) begin
                em_c = 0;
                if (++em_x >= w) begin
                    em_x = 0;
                    em_y++;
                end
            end
        endfunction

        function void check_result(out_sample_t got);
            out_sample_t exp_o;
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: output with none expected: %p", got);
                return;
            end
            exp_o = expected_outputs.pop_front();
            if (got !== exp_o) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected %p, actual %p", exp_o, got);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [12:0]        cfg_data;
    logic               item_valid;
    logic               item_stall;
    logic [1:0]         action;
    logic [5:0]         coef_index;
    logic signed [17:0] coef_value;
    logic signed [15:0] pixel_value;
    logic               result_valid;
    logic               result_stall;
    logic signed [15:0] result_value;
    logic [7:0]         out_x;
    logic [11:0]        out_y;
    logic [1:0]         out_channel;
    logic               saturated;
    logic               last;

    conv_scoreboard board;
    bit          tx_no_idle;
    bit          rx_no_idle;
    int unsigned items_sent;
    int unsigned random_items;
    int unsigned results_seen;
    int unsigned frames_run;

    conv2d_window_padding DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .item_valid(item_valid), .item_stall(item_stall),
        .action(action), .coef_index(coef_index), .coef_value(coef_value),
        .pixel_value(pixel_value),
        .result_valid(result_valid), .result_stall(result_stall),
        .result_value(result_value), .out_x(out_x), .out_y(out_y),
        .out_channel(out_channel), .saturated(saturated), .last(last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_item(input logic [1:0] act, input logic [5:0] idx,
                             input logic signed [17:0] cv, input logic signed [15:0] pv);
        int unsigned gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        action      <= act;
        coef_index  <= idx;
        coef_value  <= cv;
        pixel_value <= pv;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        board.note_input(act, idx, cv, pv);
        items_sent++;
    endtask

    // Waits until every predicted output has arrived and the engine is quiet.
    task automatic drain_block();
        item_valid <= 1'b0;
        while (board.expected_outputs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int w, input int h, input int nc,
                             input int kwid, input int khgt, input logic pm);
        logic [12:0] vals[6];
        drain_block();
        vals[0] = 13'(w); vals[1] = 13'(h); vals[2] = 13'(nc); vals[3] = 13'(kwid);
        vals[4] = 13'(khgt);
        vals[5] = {12'd0, pm};
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            board.set_register(3'(i), vals[i]);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        frames_run++;
        tx_no_idle = ($urandom_range(0, 3) == 0);
    endtask

    function automatic logic signed [15:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [17:0] pick_coef();
        if ($urandom_range(0, 4) == 0) return 18'($urandom);
        return 18'($urandom_range(0, 16383)) - 18'sd8192;
    endfunction

    task automatic flush_until_idle();
        while (!board.frame_idle())
            send_item(ACT_FLUSH, 6'($urandom), 18'($urandom), 16'($urandom));
    endtask

    // Mostly pixels with random content, mixed with loads, noise and flushes.
    task automatic run_frame();
        int unsigned r;
        bit started;
        started = 0;
        while (!(started && board.frame_idle()))
        begin
            r = $urandom_range(0, 99);
            if (!board.in_done)
            begin
                if (r < 85)
                begin
                    send_item(ACT_PIXEL, 6'($urandom), 18'($urandom), pick_pixel());
                    started = 1;
                end
                else if (r < 93)
                    send_item(ACT_COEF, 6'($urandom_range(0, COEFS - 1)), pick_coef(),
                              16'($urandom));
                else if (r < 97)
                    send_item(ACT_COEF, 6'($urandom_range(COEFS, 63)), pick_coef(),
                              16'($urandom));
                else
                    send_item(ACT_UNUSED, 6'($urandom), 18'($urandom), 16'($urandom));
            end
            else if (r < 80)
                send_item(ACT_FLUSH, 6'($urandom), 18'($urandom), 16'($urandom));
            else if (r < 92)
                send_item(ACT_PIXEL, 6'($urandom), 18'($urandom), pick_pixel());
            else
                send_item(ACT_UNUSED, 6'($urandom), 18'($urandom), 16'($urandom));
            random_items++;
        end
    endtask

    initial
    begin
        int unsigned gap;
        result_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (results_seen % 64 == 0) rx_no_idle = ($urandom_range(0, 3) == 0);
            gap = rx_no_idle ? 0 : $urandom_range(0, 19);
            // One long hold-off lets the block fill up and stall its input.
            if (results_seen == HOLD_AT) gap = LONG_HOLD;
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
            board.check_result({result_value, out_x, out_y, out_channel, saturated, last});
            results_seen++;
        end
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        board = new();
        cfg_write   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        item_valid  <= 1'b0;
        action      <= ACT_FLUSH;
        coef_index  <= '0;
        coef_value  <= '0;
        pixel_value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: coefficient extremes, ignored loads, unused action code.
        configure(2, 2, 1, 3, 3, PAD_ZERO);
        send_item(ACT_COEF, 0, 18'sh20000, 0);
        send_item(ACT_COEF, 4, 18'sh1ffff, 0);
        send_item(ACT_COEF, 8, 18'sh10000, 0);
        send_item(ACT_COEF, 48, 18'sh00100, 0);
        send_item(ACT_COEF, 63, 18'sh1ffff, 0);
        send_item(ACT_UNUSED, 6'h3f, 18'sh3ffff, 16'shffff);
        send_item(ACT_FLUSH, 0, 0, 0);
        send_item(ACT_PIXEL, 0, 0, 16'sh7fff);
        send_item(ACT_PIXEL, 0, 0, 16'sh8000);
        send_item(ACT_PIXEL, 0, 0, 16'sh7fff);
        send_item(ACT_PIXEL, 0, 0, 16'sh0001);
        flush_until_idle();
        // Mirror padding, with a sample offered after the frame is complete.
        configure(2, 2, 1, 3, 3, PAD_MIRROR);
        send_item(ACT_PIXEL, 0, 0, 16'sh0100);
        send_item(ACT_PIXEL, 0, 0, 16'sh8000);
        send_item(ACT_PIXEL, 0, 0, 16'sh7fff);
        send_item(ACT_PIXEL, 0, 0, 16'shff00);
        send_item(ACT_PIXEL, 0, 0, 16'sh1234);
        flush_until_idle();

        // Register extremes: zero frame sizes act as one; oversize ones clamp.
        configure(0, 0, 0, 0, 0, PAD_ZERO);
        run_frame();
        configure(4, 3, 7, 7, 7, PAD_MIRROR);
        run_frame();
        configure(511, 1, 1, 7, 1, PAD_MIRROR);
        run_frame();
        configure(1, 9, 1, 0, 7, PAD_ZERO);
        run_frame();
        random_items = 0;

        while (random_items < RANDOM_ITEMS)
        begin
            configure($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 4),
                      $urandom_range(0, 7), $urandom_range(0, 7),
                      1'($urandom_range(0, 1)));
            run_frame();
        end

        drain_block();
        $display("Ran %0d frames with %0d transactions; %0d output samples checked.",
                 frames_run, items_sent, results_seen);
        $display("Covered zero and mirror borders, clamped sizes and full-scale values.");
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
